/* src/gb3_pkg.sv */
// ----------------------------------------------------------------------------
// Gaussian blur 3x3 package
// Shared payload types, register indexes and output queue sizing.
// ----------------------------------------------------------------------------
package gb3_pkg;

    // Request payload on the pixel input channel.
    typedef struct packed {
        logic [7:0] pixel_in;
        logic       frame_start;
    } t_pix_in;

    // Request payload on the filtered output channel.
    typedef struct packed {
        logic [7:0] pixel_out;
        logic       row_end;
        logic       frame_end;
    } t_pix_out;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 12'd480;

    // Output queue.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

endpackage

/* src/gb3_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write port and one read port with a registered read; a read of the
// address written at the same edge returns the old contents.
// ----------------------------------------------------------------------------
module gb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/gaussian_blur_3x3_stream.sv */
// ----------------------------------------------------------------------------
// Gaussian blur 3x3 stream
// Raster-order 8-bit grey pixels in, 1-2-1 Gaussian value of every interior
// pixel out, built around two line memories and a 3x2 window register set.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                      | Payload
//  ---------+--------------------------------+---------------------------------
//  in       | i_in_valid  / o_in_ready       | i_in_data  (pixel_in, frame_start)
//  out      | o_out_valid / i_out_ready      | o_out_data (pixel_out, row_end,
//           |                                |             frame_end)
//  cfg      | i_cfg_we (no ready)            | i_cfg_index, i_cfg_data
//
//  One pixel request is taken per clock while o_in_ready is high. The line
//  memories are read at the accepting edge and the pixel is filtered in the
//  next cycle, then its result is written into the output queue.
//  Input ready drops only when the four-entry output queue and the pixel
//  being filtered could overflow it. Reset (i_rst_n low, synchronous) clears
//  counters, window and queue and loads the default geometry, not the memories.
//
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_stream #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Pixel input
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  gb3_pkg::t_pix_in                 i_in_data,
    // Filtered output
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output gb3_pkg::t_pix_out                o_out_data,
    // Configuration writes
    input  logic                             i_cfg_we,
    input  logic [gb3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import gb3_pkg::*;

    // Column counter and line memory address width.
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    // Width used to clamp the configured image width against MAX_WIDTH.
    localparam int WW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
    localparam int RW = CFG_DATA_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] r_image_width;
    logic [CFG_DATA_W-1:0] r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The width in use is clamped to [3, MAX_WIDTH], the height is raised
    // to at least 3. Only the index of the last column and row is needed.
    logic [WW-1:0] w_ext;
    logic [WW-1:0] w_eff;
    logic [CW-1:0] col_last_idx;
    logic [RW-1:0] row_last_idx;

    always_comb begin
        w_ext = WW'(r_image_width);
        if (w_ext < WW'(3)) begin
            w_eff = WW'(3);
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        col_last_idx = CW'(w_eff - WW'(1));
        row_last_idx = (r_image_height < RW'(3)) ? RW'(2) : (r_image_height - RW'(1));
    end

    // ------------------------------------------------------------------
    // Accept stage: position counters and line memory read
    // ------------------------------------------------------------------
    logic          in_acc;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic          is_col_last;
    logic          is_row_last;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    assign in_acc = i_in_valid && o_in_ready;

    always_comb begin
        // A frame start zeroes the position before this pixel is placed.
        cur_col     = i_in_data.frame_start ? '0 : r_col;
        cur_row     = i_in_data.frame_start ? '0 : r_row;
        is_col_last = (cur_col >= col_last_idx);
        is_row_last = (cur_row >= row_last_idx);
        if (is_col_last) begin
            n_col = '0;
            n_row = is_row_last ? '0 : cur_row + RW'(1);
        end else begin
            n_col = cur_col + CW'(1);
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Filter stage registers: one pixel, valid for exactly one cycle.
    logic          r_s1_valid;
    logic [CW-1:0] r_s1_idx;
    logic [7:0]    r_s1_pix;
    logic          r_s1_emit;
    logic          r_s1_row_end;
    logic          r_s1_frame_end;
    // Forwarding for a read of the entry written at the same edge.
    logic          r_s1_fwd;
    logic [7:0]    r_s1_fwd_top;
    logic [7:0]    r_s1_fwd_mid;

    logic [7:0]    ram_top;
    logic [7:0]    ram_mid;
    logic [7:0]    top;
    logic [7:0]    mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_idx       <= cur_col;
            r_s1_pix       <= i_in_data.pixel_in;
            r_s1_emit      <= (cur_col >= CW'(2)) && (cur_row >= RW'(2));
            r_s1_row_end   <= is_col_last;
            r_s1_frame_end <= is_col_last && is_row_last;
            // The pixel now being filtered writes its column at this edge;
            // the memory would still return the old contents.
            r_s1_fwd       <= r_s1_valid && (r_s1_idx == cur_col);
            r_s1_fwd_top   <= mid;
            r_s1_fwd_mid   <= r_s1_pix;
        end
    end

    // Upper line memory holds row r-2, middle holds row r-1. Each pixel
    // shifts its column down: middle moves to upper, the new pixel to middle.
    gb3_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_idx),
        .i_wdata (mid),
        .i_re    (in_acc),
        .i_raddr (cur_col),
        .o_rdata (ram_top)
    );

    gb3_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_idx),
        .i_wdata (r_s1_pix),
        .i_re    (in_acc),
        .i_raddr (cur_col),
        .o_rdata (ram_mid)
    );

    assign top = r_s1_fwd ? r_s1_fwd_top : ram_top;
    assign mid = r_s1_fwd ? r_s1_fwd_mid : ram_mid;

    // ------------------------------------------------------------------
    // Filter stage: window shift and tap sum
    // ------------------------------------------------------------------
    // r_win[0..2] is column c-2, top to bottom; r_win[3..5] is column c-1.
    logic [7:0] r_win [6];
    logic [9:0] tap_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s1_valid) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= r_s1_pix;
        end
    end

    // Every tap is truncated on its own before the sum; the largest
    // possible total is 247, so the sum fits in eight bits.
    always_comb begin
        tap_sum = 10'(r_win[0] >> 4) + 10'(r_win[3] >> 3) + 10'(top >> 4)
                + 10'(r_win[1] >> 3) + 10'(r_win[4] >> 2) + 10'(mid >> 3)
                + 10'(r_win[2] >> 4) + 10'(r_win[5] >> 3) + 10'(r_s1_pix >> 4);
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    t_pix_out         r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_oq_wptr;
    logic [OQ_AW-1:0] r_oq_rptr;
    logic [OQ_CW-1:0] r_oq_count;
    logic             oq_push;
    logic             oq_pop;
    t_pix_out         oq_wdata;

    assign oq_push = r_s1_valid && r_s1_emit;
    assign oq_pop  = o_out_valid && i_out_ready;

    always_comb begin
        oq_wdata.pixel_out = tap_sum[7:0];
        oq_wdata.row_end   = r_s1_row_end;
        oq_wdata.frame_end = r_s1_frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wptr] <= oq_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wptr  <= '0;
            r_oq_rptr  <= '0;
            r_oq_count <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wptr <= r_oq_wptr + OQ_AW'(1);
            end
            if (oq_pop) begin
                r_oq_rptr <= r_oq_rptr + OQ_AW'(1);
            end
            case ({oq_push, oq_pop})
                2'b10:   r_oq_count <= r_oq_count + OQ_CW'(1);
                2'b01:   r_oq_count <= r_oq_count - OQ_CW'(1);
                default: r_oq_count <= r_oq_count;
            endcase
        end
    end

    // A new pixel is taken only if the queue has room for it and for the
    // pixel currently in the filter stage, whether or not either emits.
    assign o_in_ready  = ((r_oq_count + OQ_CW'(r_s1_valid)) < OQ_CW'(OQ_DEPTH - 1))
                       || ((r_oq_count + OQ_CW'(r_s1_valid)) == OQ_CW'(OQ_DEPTH - 1));
    assign o_out_valid = (r_oq_count != '0);
    assign o_out_data  = r_oq[r_oq_rptr];

endmodule

/* src/gb3_checker.sv */
// ----------------------------------------------------------------------------
// Gaussian blur 3x3 port checker
// Watches the top-level ports for handshake and result ordering slips.
// ----------------------------------------------------------------------------
module gb3_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input gb3_pkg::t_pix_out i_out_data
);

    import gb3_pkg::*;

    // A stalled result request keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output request changed while stalled");

    // The last pixel of a frame is also the last pixel of its row.
    a_frame_end_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.frame_end |-> i_out_data.row_end)
        else $error("frame end without row end");

    // An empty output starts up only after a pixel was taken and filtered.
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without a matching pixel request");

    // Reset empties the output queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind gaussian_blur_3x3_stream gb3_checker u_gb3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian blur 3x3 stream testbench
// Streams raster frames of corner-case and random grey pixels through the
// filter under random back-pressure on both channels. An in-bench model of
// the line stores, the window and the position counters predicts every
// interior result. Each filtered pixel and its row and frame end flags are
// checked in order.
// ----------------------------------------------------------------------------
module tb;
    import gb3_pkg::*;

    localparam int MAX_W         = 2048;
    localparam int IDLE_PCT      = 19;
    localparam int RANDOM_PIXELS = 1300;
    localparam int QUIET_PIXELS  = 300;
    localparam int WIDE_W        = 64;
    // A pixel reaches the output queue in the cycle after it is taken, so the
    // settling wait after the last expected result leaves the pipeline empty.
    localparam int SETTLE_CYCLES = 4;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_pix_in               in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_pix_out              out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Random idling on the sender and the receiver side.
    bit in_idle_on;
    bit out_idle_on;

    int unsigned sent_count;
    int unsigned mismatch_count;

    // Filter model: two previous rows, the two previous window columns
    // (top to bottom, oldest column first) and the raster position.
    bit [7:0]              line_upper [MAX_W];
    bit [7:0]              line_middle [MAX_W];
    bit [7:0]              win_reg [6];
    int unsigned           col_pos;
    int unsigned           row_pos;
    logic [CFG_DATA_W-1:0] geo_width;
    logic [CFG_DATA_W-1:0] geo_height;

    // Filtered pixels still owed by the block, oldest first.
    t_pix_out blurred_q [$];

    gaussian_blur_3x3_stream #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Row length in use: the register clamped to what the line stores hold.
    function automatic int unsigned eff_width();
        if (geo_width < 3) return 3;
        if (geo_width > MAX_W) return MAX_W;
        return geo_width;
    endfunction

    // Frame height in use: never fewer than the three rows of the window.
    function automatic int unsigned eff_height();
        if (geo_height < 3) return 3;
        return geo_height;
    endfunction

    // Takes one pixel request into the filter model. Returns 1 when the pixel
    // completes the window of an interior pixel, with that result in res.
    function automatic bit blur_pixel(input t_pix_in px, output t_pix_out res);
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        int unsigned top;
        int unsigned mid;
        int unsigned pix;
        int unsigned sum;
        bit          emit;
        bit          last_col;
        w = eff_width();
        h = eff_height();
        if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        idx = col_pos % MAX_W;
        pix = px.pixel_in;
        top = line_upper[idx];
        mid = line_middle[idx];
        line_upper[idx]  = 8'(mid);
        line_middle[idx] = 8'(pix);

        // Every tap is truncated on its own before the sum.
        sum = win_reg[0] / 16 + win_reg[3] / 8 + top / 16
            + win_reg[1] / 8  + win_reg[4] / 4 + mid / 8
            + win_reg[2] / 16 + win_reg[5] / 8 + pix / 16;
        last_col      = (col_pos >= w - 1);
        emit          = (col_pos >= 2) && (row_pos >= 2);
        res.pixel_out = 8'(sum);
        res.row_end   = last_col;
        res.frame_end = last_col && (row_pos >= h - 1);

        win_reg[0] = win_reg[3];
        win_reg[1] = win_reg[4];
        win_reg[2] = win_reg[5];
        win_reg[3] = 8'(top);
        win_reg[4] = 8'(mid);
        win_reg[5] = 8'(pix);

        // A column or row past the last one (after a shrink) wraps as well.
        if (last_col) begin
            col_pos = 0;
            row_pos = (row_pos >= h - 1) ? 0 : ((row_pos + 1) & 12'hFFF);
        end else begin
            col_pos = col_pos + 1;
        end
        return emit;
    endfunction

    // All sampling happens here, on the rising edge. Results are checked
    // before the pixel accepted in the same cycle is modeled; a pixel never
    // produces its own result in the cycle it is accepted.
    always @(posedge clk) begin : result_monitor
        t_pix_out expd;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (blurred_q.size() == 0) begin
                    $error("filtered pixel %0d arrived with no result pending",
                           out_data.pixel_out);
                    mismatch_count++;
                end else begin
                    expd = blurred_q.pop_front();
                    if (out_data.pixel_out !== expd.pixel_out) begin
                        $error("pixel_out: expected %0d, actual %0d",
                               expd.pixel_out, out_data.pixel_out);
                        mismatch_count++;
                    end
                    if (out_data.row_end !== expd.row_end) begin
                        $error("row_end: expected %0b, actual %0b",
                               expd.row_end, out_data.row_end);
                        mismatch_count++;
                    end
                    if (out_data.frame_end !== expd.frame_end) begin
                        $error("frame_end: expected %0b, actual %0b",
                               expd.frame_end, out_data.frame_end);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                if (blur_pixel(in_data, expd)) blurred_q.push_back(expd);
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH: begin
                        geo_width = cfg_data;
                    end
                    CFG_IMAGE_HEIGHT: begin
                        geo_height = cfg_data;
                    end
                    default: ;
                endcase
            end
        end
    end

    // The receiver stalls at random while out_idle_on is set.
    always @(negedge clk) begin
        out_ready <= out_idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    // Grey values with the two extremes overrepresented.
    function automatic logic [7:0] rand_pixel();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) return 8'd0;
        if (pick < 16) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    // Offers one pixel request and waits until it is taken. Entered and left
    // at a falling edge; valid stays high between back-to-back requests.
    task automatic send_pixel(input logic [7:0] value, input logic fs);
        while (in_idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{pixel_in: value, frame_start: fs};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        sent_count++;
    endtask

    // Sends count random pixels. lead_fs marks the first one as a frame start;
    // stray_permille adds restarts in the middle of the run.
    task automatic send_frame(input int unsigned count, input bit lead_fs,
                              input int unsigned stray_permille);
        for (int unsigned i = 0; i < count; i++) begin
            send_pixel(rand_pixel(),
                       (i == 0) ? lead_fs : ($urandom_range(999) < stray_permille));
        end
    endtask

    // Holds the sender off until every owed result has come out and the
    // pipeline has drained, so that the block is idle afterwards.
    task automatic settle();
        in_valid <= 1'b0;
        while (blurred_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes the geometry registers selected by do_w and do_h. Only called
    // while the block is idle.
    task automatic set_geometry(input bit do_w, input logic [CFG_DATA_W-1:0] w,
                                input bit do_h, input logic [CFG_DATA_W-1:0] h);
        if (do_w) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IMAGE_WIDTH;
            cfg_data  <= w;
            @(negedge clk);
        end
        if (do_h) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IMAGE_HEIGHT;
            cfg_data  <= h;
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Smallest frames: an all-white frame gives the largest possible sum,
    // an all-black one follows by counter wrap alone, then a checkerboard.
    task automatic test_directed_frames();
        set_geometry(1'b1, 12'd3, 1'b1, 12'd3);
        for (int i = 0; i < 9; i++) send_pixel(8'd255, i == 0);
        for (int i = 0; i < 9; i++) send_pixel(8'd0, 1'b0);
        for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'd255 : 8'd0, i == 0);
    endtask

    // Width and height below three must act as a 3x3 frame.
    task automatic test_clamped_geometry();
        for (int i = 0; i < 2; i++) begin
            settle();
            set_geometry(1'b1, 12'($urandom_range(2)), 1'b1, 12'($urandom_range(2)));
            send_frame(9, 1'b1, 0);
        end
    endtask

    // Shrinks the width while the column counter is already past the new
    // last column, then the height while the row counter is past the new
    // last row. Both counters must wrap, and the next frame must start
    // without a frame start marker.
    task automatic test_counter_wrap();
        settle();
        set_geometry(1'b1, 12'd8, 1'b1, 12'd6);
        send_frame(3 * 8 + 6, 1'b1, 0);
        settle();
        set_geometry(1'b1, 12'd4, 1'b0, '0);
        send_frame(1 + 4, 1'b0, 0);
        settle();
        set_geometry(1'b0, '0, 1'b1, 12'd3);
        send_frame(4, 1'b0, 0);
        send_frame(4 * 3, 1'b0, 0);
    endtask

    // Tallest setting: a dozen rows must give row ends but no frame end.
    task automatic test_tall_frame();
        settle();
        set_geometry(1'b1, 12'd3, 1'b1, 12'hFFF);
        send_frame(3 * 12, 1'b1, 0);
    endtask

    // Wide frame: one full three-row frame with rows well beyond the random
    // widths, reaching line store entries that no other test uses.
    task automatic test_wide_frame();
        settle();
        set_geometry(1'b1, 12'(WIDE_W), 1'b1, 12'd3);
        send_frame(WIDE_W * 3, 1'b1, 0);
    endtask

    // Mostly complete frames of random small geometry, with some cut short,
    // some started by counter wrap, and rare restarts in mid-frame. The first
    // few hundred pixels run with no idling on either side.
    task automatic test_random_frames();
        int unsigned           start;
        int unsigned           full;
        int unsigned           count;
        int unsigned           pick;
        logic [CFG_DATA_W-1:0] new_w;
        logic [CFG_DATA_W-1:0] new_h;
        bit                    lead_fs;
        start       = sent_count;
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        while (sent_count - start < RANDOM_PIXELS) begin
            settle();
            if (sent_count - start >= QUIET_PIXELS) begin
                in_idle_on  = ($urandom_range(99) < 80);
                out_idle_on = ($urandom_range(99) < 80);
            end
            if ($urandom_range(99) < 60) begin
                pick  = $urandom_range(99);
                new_w = (pick < 10) ? 12'($urandom_range(2))
                      : (pick < 80) ? 12'($urandom_range(10, 3))
                      : 12'($urandom_range(40, 11));
                pick  = $urandom_range(99);
                new_h = (pick < 10) ? 12'($urandom_range(2)) : 12'($urandom_range(8, 3));
                set_geometry(1'($urandom_range(1)), new_w, 1'($urandom_range(1)), new_h);
            end
            full  = eff_width() * eff_height();
            count = ($urandom_range(99) < 10) ? $urandom_range(full - 1, 1) : full;
            // Counter wrap may start a frame only when the last one was whole.
            lead_fs = !(col_pos == 0 && row_pos == 0 && $urandom_range(99) < 15);
            send_frame(count, lead_fs, 5);
        end
        settle();
    endtask

    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_IMAGE_WIDTH;
        cfg_data    = '0;
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        geo_width   = RST_IMAGE_WIDTH;
        geo_height  = RST_IMAGE_HEIGHT;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_frames();
        test_clamped_geometry();
        test_counter_wrap();
        test_tall_frame();
        test_wide_frame();
        test_random_frames();

        // Any result beyond the owed ones shows up in these extra cycles.
        repeat (20) @(negedge clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
